>>> rtl/scb_pkg.sv
package scb_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int COL_W = 10;
  localparam int POS_W = 16;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_INSERT = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] start;
    logic [COL_W-1:0] stop;
  } span_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> rtl/scb_if.sv
interface scb_req_if import scb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [POS_W-1:0]  span_start;
  logic [POS_W-1:0]  span_end;
  modport source(output valid, opcode, span_start, span_end, input ready);
  modport sink(input valid, opcode, span_start, span_end, output ready);
endinterface

interface scb_rsp_if import scb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  vis_start;
  logic [COL_W-1:0]  vis_end;
  logic              has_span;
  logic              last;
  logic              screen_full;
  logic              out_of_entries;
  modport source(output valid, vis_start, vis_end, has_span, last, screen_full,
                 out_of_entries, input ready);
  modport sink(input valid, vis_start, vis_end, has_span, last, screen_full,
               out_of_entries, output ready);
endinterface

>>> rtl/span_coverage_buffer.sv
// Keeps up to MAX_ENTRIES sorted, disjoint spans of undrawn columns in a row of cells that
// acts as a queue. A query or insert rotates every stored span once through the head cell,
// one span per cycle unless a held result waits on the result side, emitting overlaps in
// column order and writing kept, trimmed or split spans back at the tail; a split writes its
// second piece in a state of its own. One result leaves per cycle while the result side
// takes it, held back by one stage so the final one can be marked last.
module span_coverage_buffer import scb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [COL_W-1:0] cfg_wdata,
  scb_req_if.sink          req,
  scb_rsp_if.source        rsp
);

  state_t           state, state_next;
  logic [COL_W-1:0] screen_width;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] remaining;
  logic             ins;
  logic signed [POS_W-1:0] s_q, e_q;
  logic             full_q, flow_q;
  logic             pend_v;
  span_t            pend, split_hold;

  span_t            cell_q [MAX_ENTRIES];
  cell_ctl_t        cell_ctl [MAX_ENTRIES];
  span_t            push_data;
  logic             pop, push, clr_load;
  logic [CNT_W-1:0] wr_idx;

  logic signed [POS_W-1:0] a, b, lo, hi, s_in, e_in, w_s, first_s, tail_e;
  logic             hit, split, split_ok, advance, out_free, accept, active;
  opcode_t          op_in;

  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign accept = req.valid && req.ready;
  assign op_in = opcode_t'(req.opcode);
  assign s_in = req.span_start;
  assign e_in = req.span_end;
  assign w_s = POS_W'(screen_width);
  assign first_s = POS_W'(cell_q[0].start);
  assign tail_e = POS_W'(cell_q[IDX_W'(count - CNT_W'(1))].stop);
  assign active = (op_in == OP_QUERY || op_in == OP_INSERT) && count != '0
                  && e_in > 0 && s_in < w_s && s_in < e_in;

  // head cell against the current interval
  always_comb begin
    a = POS_W'(cell_q[0].start);
    b = POS_W'(cell_q[0].stop);
    lo = (a > s_q) ? a : s_q;
    hi = (b < e_q) ? b : e_q;
    hit = lo < hi;
    split = ins && hit && a < s_q && b > e_q;
    split_ok = split && count < CNT_W'(MAX_ENTRIES);
    advance = (state == ST_WALK) && (!(hit && pend_v) || out_free);
  end

  always_comb begin
    pop = 1'b0;
    push = 1'b0;
    push_data = cell_q[0];
    clr_load = accept && op_in == OP_CLEAR;
    if (advance) begin
      pop = 1'b1;
      if (!hit || !ins || (split && !split_ok)) begin
        push = 1'b1;
      end else if (a < s_q) begin
        push = 1'b1;
        push_data.stop = s_q[COL_W-1:0];
      end else if (b > e_q) begin
        push = 1'b1;
        push_data.start = e_q[COL_W-1:0];
      end
    end else if (state == ST_SPLIT) begin
      push = 1'b1;
      push_data = split_hold;
    end
    if (clr_load) begin
      push_data.start = '0;
      push_data.stop = screen_width;
    end
    wr_idx = clr_load ? '0 : (pop ? count - CNT_W'(1) : count);
    count_next = count - CNT_W'(pop) + CNT_W'(push);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_ctl[i].shift = pop;
      cell_ctl[i].load = (push || clr_load) && wr_idx[IDX_W-1:0] == IDX_W'(i);
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    scb_cell u_cell (
      .clk(clk),
      .ctl(cell_ctl[g]),
      .nbr(cell_q[(g == MAX_ENTRIES - 1) ? g : g + 1]),
      .din(push_data),
      .q(cell_q[g])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = active ? ST_WALK : ST_FLUSH;
      end
      ST_WALK: begin
        if (advance) begin
          if (split_ok) state_next = ST_SPLIT;
          else if (remaining == CNT_W'(1)) state_next = ST_FLUSH;
        end
      end
      ST_SPLIT: state_next = (remaining == '0) ? ST_FLUSH : ST_WALK;
      ST_FLUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      screen_width <= COL_W'(256);
      count <= '0;
      pend_v <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) screen_width <= cfg_wdata;
      if (clr_load) count <= (screen_width != '0) ? CNT_W'(1) : '0;
      else count <= count_next;
      if (advance && hit) begin
        pend_v <= 1'b1;
      end else if (state == ST_FLUSH && out_free) begin
        pend_v <= 1'b0;
      end
      if (out_free) begin
        rsp.valid <= (advance && hit && pend_v) || state == ST_FLUSH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ins <= (op_in == OP_INSERT);
      s_q <= s_in;
      e_q <= e_in;
      remaining <= count;
      flow_q <= 1'b0;
      if (op_in == OP_CLEAR) full_q <= (screen_width == '0);
      else if (active) full_q <= (op_in == OP_INSERT) && s_in <= first_s && e_in >= tail_e;
      else full_q <= (count == '0);
    end
    if (advance) begin
      remaining <= remaining - CNT_W'(1);
      if (split && !split_ok) flow_q <= 1'b1;
      if (hit) begin
        pend.start <= lo[COL_W-1:0];
        pend.stop <= hi[COL_W-1:0];
      end
      split_hold.start <= e_q[COL_W-1:0];
      split_hold.stop <= b[COL_W-1:0];
    end
    if (out_free && ((advance && hit && pend_v) || state == ST_FLUSH)) begin
      rsp.vis_start <= pend_v ? pend.start : '0;
      rsp.vis_end <= pend_v ? pend.stop : '0;
      rsp.has_span <= pend_v;
      rsp.last <= (state == ST_FLUSH);
      rsp.screen_full <= full_q;
      rsp.out_of_entries <= flow_q;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES)) else $error("span store over capacity");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v) else $error("held result left behind");
  a_split_insert: assert property (@(posedge clk) disable iff (rst)
    state == ST_SPLIT |-> ins && $past(state) == ST_WALK)
    else $error("split outside insert walk");
`endif

endmodule

>>> rtl/scb_cell.sv
module scb_cell import scb_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  span_t     nbr,
  input  span_t     din,
  output span_t     q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= din;
    end else if (ctl.shift) begin
      q <= nbr;
    end
  end

endmodule
